FILE: rtl/core/scar_pkg.sv
// Package for the stereo comb/allpass reverb: constants, types and delay-length functions.
// Depends on nothing; the top level of the reverb imports it.
`timescale 1ns / 1ps
package scar_pkg;

  localparam int NumCombsDef     = 8;
  localparam int NumAllpassesDef = 4;
  localparam int MaxDelayDef     = 2048;
  localparam int SampleRateDef   = 44100;
  localparam int SpreadDef       = 23;

  localparam int SendGainQ16  = 3932;
  localparam int RoomScaleQ16 = 18350;
  localparam int RoomOffQ16   = 45875;
  localparam int DampScaleQ16 = 26214;

  localparam logic signed [23:0] LineMax = 24'sh7FFFFF;
  localparam logic signed [23:0] LineMin = -24'sh800000;

  localparam logic [1:0] RegRoom = 2'd0;
  localparam logic [1:0] RegDamp = 2'd1;
  localparam logic [1:0] RegWet  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMB_RD,
    ST_COMB_WR,
    ST_AP_RD,
    ST_AP_WR,
    ST_MIX,
    ST_OUT
  } state_t;

  function automatic int comb_base(input int i);
    case (i % 8)
      0: comb_base = 1116;
      1: comb_base = 1188;
      2: comb_base = 1277;
      3: comb_base = 1356;
      4: comb_base = 1422;
      5: comb_base = 1491;
      6: comb_base = 1557;
      default: comb_base = 1617;
    endcase
  endfunction

  function automatic int ap_tune(input int i);
    case (i % 4)
      0: ap_tune = 556;
      1: ap_tune = 441;
      2: ap_tune = 341;
      default: ap_tune = 225;
    endcase
  endfunction

  // Length of a line, evaluated at elaboration only.
  function automatic int line_len(input int tune, input int chan, input int rate,
                                  input int spread, input int maxd);
    longint d;
    d = (longint'(tune) * longint'(rate)) / 64'sd44100;
    if (chan != 0) d = d + longint'(spread);
    if (d < 1) d = 1;
    if (d > maxd) d = maxd;
    line_len = int'(d);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) sat24 = LineMax;
    else if (v < -48'sd8388608) sat24 = LineMin;
    else sat24 = v[23:0];
  endfunction

endpackage

FILE: rtl/core/scar_if.sv
// Valid/ready channel interfaces for the reverb.
// Depends on nothing.
`timescale 1ns / 1ps
interface scar_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left;
  logic signed [15:0] right;
  modport source (output valid, output left, output right, input ready);
  modport sink (input valid, input left, input right, output ready);
endinterface

interface scar_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/scar_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module scar_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/stereo_comb_allpass_reverb_top.sv
// Top level of the stereo comb/allpass reverb: sequencer, shared multiplier, delay RAMs.
// Depends on scar_pkg, scar_if and scar_ram.
//
//  channel   | dir | payload                    | handshake
//  ----------+-----+----------------------------+-------------
//  smp_in    | in  | left, right (Q1.15)        | valid/ready
//  smp_out   | out | left, right (Q1.15, sat)   | valid/ready
//  cfg       | in  | index (2b), data (16b)     | valid/ready
//
// Each comb has a read state and then forms o*d2, lp*d1 and lp*fb on the single shared
// 24x17 multiplier; each allpass has a read state and a write state, and each channel
// ends with a mix state. The output pair is held until taken; the next sample, and any
// configuration write, is accepted only in the idle state.
// After reset a clearing pass writes zero to every delay word, one per cycle; no sample
// is taken then.
`timescale 1ns / 1ps
module stereo_comb_allpass_reverb_top
  import scar_pkg::*;
#(
  parameter int NUM_COMBS      = NumCombsDef,
  parameter int NUM_ALLPASSES  = NumAllpassesDef,
  parameter int MAX_DELAY      = MaxDelayDef,
  parameter int SAMPLE_RATE_HZ = SampleRateDef,
  parameter int SPREAD_SAMPLES = SpreadDef
) (
  input  logic          clk,
  input  logic          rst,
  scar_sample_if.sink   smp_in,
  scar_sample_if.source smp_out,
  scar_cfg_if.sink      cfg
);

  localparam int NC   = 2 * NUM_COMBS;
  localparam int NA   = 2 * NUM_ALLPASSES;
  localparam int CW   = $clog2(NC);
  localparam int AW   = $clog2(NA);
  localparam int PW   = $clog2(MAX_DELAY + 1);
  localparam int DW   = $clog2(MAX_DELAY);
  localparam int CADW = CW + DW;
  localparam int AADW = AW + DW;
  localparam int XW   = (CADW > AADW) ? CADW : AADW;
  localparam int TW   = 24 + CW;

  // Lengths per line, filled at elaboration.
  logic [PW-1:0] comb_len [NC];
  logic [PW-1:0] ap_len [NA];
  for (genvar g = 0; g < NC; g++) begin : g_cl
    assign comb_len[g] = PW'(line_len(comb_base(g % NUM_COMBS), g / NUM_COMBS,
                                      SAMPLE_RATE_HZ, SPREAD_SAMPLES, MAX_DELAY));
  end
  for (genvar g = 0; g < NA; g++) begin : g_al
    assign ap_len[g] = PW'(line_len(ap_tune(g % NUM_ALLPASSES), g / NUM_ALLPASSES,
                                    SAMPLE_RATE_HZ, SPREAD_SAMPLES, MAX_DELAY));
  end

  // Sequencer state.
  state_t state, state_next;
  logic [XW-1:0] clr_cnt;
  logic [CW-1:0] ci;
  logic [AW-1:0] ai;
  logic [1:0]    phase;
  logic          chan;
  logic signed [15:0] dry_l, dry_r, out_l, out_r;
  logic signed [23:0] send, acc, lp_val, o_val;
  logic signed [23:0] lp_state [NC];
  logic [DW-1:0] comb_pos [NC];
  logic [DW-1:0] ap_pos [NA];
  logic signed [47:0] prod_reg;
  logic signed [TW-1:0] comb_total, comb_total_next;

  // Configuration registers and coefficients.
  logic [15:0] room_size, damping, wet_level;
  logic [32:0] room_prod, damp_prod;
  logic [16:0] fb, d1, d2;

  // RAMs.
  logic comb_we, ap_we;
  logic [CADW-1:0] comb_waddr, comb_raddr;
  logic [AADW-1:0] ap_waddr, ap_raddr;
  logic [23:0] comb_wdata, comb_rdata, ap_wdata, ap_rdata;

  // Shared multiplier and datapath values.
  logic signed [23:0] mul_a;
  logic [16:0] mul_b;
  logic signed [42:0] mul_p;
  logic signed [31:0] send_prod;
  logic signed [15:0] dry_sel, mix_sat;
  logic signed [47:0] lp_sum, comb_sum, ap_sum, ap_diff, mix_sum;
  logic [PW-1:0] comb_pos_inc, ap_pos_inc;
  logic [DW-1:0] comb_pos_next, ap_pos_next;
  logic last_c, last_a;

  // Registers are written only while idle, so no sample ever sees a mid-item change.
  assign cfg.ready = (state == ST_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      room_size <= 16'd47186;
      damping   <= 16'd22938;
      wet_level <= 16'd19661;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        RegRoom: room_size <= cfg.data;
        RegDamp: damping   <= cfg.data;
        RegWet:  wet_level <= cfg.data;
        default: ;
      endcase
    end
  end

  // Coefficients: constant-coefficient products, narrow.
  assign room_prod = 33'(room_size) * 33'(RoomScaleQ16);
  assign damp_prod = 33'(damping) * 33'(DampScaleQ16);
  assign fb = 17'(RoomOffQ16) + 17'(room_prod[32:16]);
  assign d1 = 17'(damp_prod[32:16]);
  assign d2 = 17'h10000 - d1;

  scar_ram #(.Width(24), .Depth(2 ** CADW)) u_comb_ram (
    .clk, .we(comb_we), .waddr(comb_waddr), .wdata(comb_wdata),
    .raddr(comb_raddr), .rdata(comb_rdata)
  );
  scar_ram #(.Width(24), .Depth(2 ** AADW)) u_ap_ram (
    .clk, .we(ap_we), .waddr(ap_waddr), .wdata(ap_wdata),
    .raddr(ap_raddr), .rdata(ap_rdata)
  );

  assign comb_raddr = {ci, comb_pos[ci]};
  assign ap_raddr   = {ai, ap_pos[ai]};

  // Shared multiplier: 24-bit signed by 17-bit unsigned. The comb phases use it for
  // o*d2, lp*d1 and lp*fb; otherwise it forms the wet gain product for the mix.
  assign mul_p = 43'(mul_a) * $signed({1'b0, mul_b});

  always_comb begin
    mul_a = acc;
    mul_b = {1'b0, wet_level};
    if (state == ST_COMB_WR) begin
      case (phase)
        2'd0: begin
          mul_a = $signed(comb_rdata);
          mul_b = d2;
        end
        2'd1: begin
          mul_a = lp_state[ci];
          mul_b = d1;
        end
        default: begin
          mul_a = lp_val;
          mul_b = fb;
        end
      endcase
    end
  end

  // Send level: the sum of both inputs times the fixed gain, floored to Q1.23.
  assign send_prod = (32'(smp_in.left) + 32'(smp_in.right)) * 32'(SendGainQ16);
  assign dry_sel   = chan ? dry_r : dry_l;

  assign last_c = (32'(ci) == (chan ? NC - 1 : NUM_COMBS - 1));
  assign last_a = (32'(ai) == (chan ? NA - 1 : NUM_ALLPASSES - 1));

  // Write-back values; every shift of a signed product floors.
  assign lp_sum          = (prod_reg + 48'(mul_p)) >>> 16;
  assign comb_sum        = 48'(send) + (48'(mul_p) >>> 16);
  assign comb_total_next = comb_total + TW'(o_val);
  assign ap_sum          = 48'(acc) + (48'($signed(ap_rdata)) >>> 1);
  assign ap_diff         = 48'($signed(ap_rdata)) - 48'(acc);
  assign mix_sum         = 48'(dry_sel) + (48'(mul_p) >>> 24);

  always_comb begin
    if (mix_sum > 48'sd32767) mix_sat = 16'sh7FFF;
    else if (mix_sum < -48'sd32768) mix_sat = 16'sh8000;
    else mix_sat = mix_sum[15:0];
  end

  assign comb_pos_inc  = PW'(comb_pos[ci]) + PW'(1);
  assign comb_pos_next = (comb_pos_inc >= comb_len[ci]) ? '0 : comb_pos_inc[DW-1:0];
  assign ap_pos_inc    = PW'(ap_pos[ai]) + PW'(1);
  assign ap_pos_next   = (ap_pos_inc >= ap_len[ai]) ? '0 : ap_pos_inc[DW-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:    if (smp_in.valid) state_next = ST_COMB_RD;
      ST_COMB_RD: state_next = ST_COMB_WR;
      ST_COMB_WR: if (phase == 2'd2) state_next = last_c ? ST_AP_RD : ST_COMB_RD;
      ST_AP_RD:   state_next = ST_AP_WR;
      ST_AP_WR:   state_next = last_a ? ST_MIX : ST_AP_RD;
      ST_MIX:     state_next = chan ? ST_OUT : ST_COMB_RD;
      ST_OUT:     if (smp_out.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  assign smp_in.ready  = (state == ST_IDLE);
  assign smp_out.valid = (state == ST_OUT);
  assign smp_out.left  = out_l;
  assign smp_out.right = out_r;

  always_comb begin
    comb_we    = 1'b0;
    comb_waddr = {ci, comb_pos[ci]};
    comb_wdata = sat24(comb_sum);
    ap_we      = (state == ST_AP_WR);
    ap_waddr   = {ai, ap_pos[ai]};
    ap_wdata   = sat24(ap_sum);
    if (state == ST_CLEAR) begin
      comb_we    = (32'(clr_cnt) < (1 << CADW));
      comb_waddr = clr_cnt[CADW-1:0];
      comb_wdata = '0;
      ap_we      = (32'(clr_cnt) < (1 << AADW));
      ap_waddr   = clr_cnt[AADW-1:0];
      ap_wdata   = '0;
    end else if (state == ST_COMB_WR && phase == 2'd2) begin
      comb_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      phase      <= '0;
      chan       <= 1'b0;
      ci         <= '0;
      ai         <= '0;
      dry_l      <= '0;
      dry_r      <= '0;
      send       <= '0;
      acc        <= '0;
      o_val      <= '0;
      lp_val     <= '0;
      prod_reg   <= '0;
      comb_total <= '0;
      out_l      <= '0;
      out_r      <= '0;
      for (int k = 0; k < NC; k++) begin
        lp_state[k] <= '0;
        comb_pos[k] <= '0;
      end
      for (int k = 0; k < NA; k++) ap_pos[k] <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + XW'(1);
        ST_IDLE: if (smp_in.valid) begin
          dry_l      <= smp_in.left;
          dry_r      <= smp_in.right;
          send       <= 24'(send_prod >>> 8);
          chan       <= 1'b0;
          ci         <= '0;
          ai         <= '0;
          phase      <= '0;
          comb_total <= '0;
        end
        ST_COMB_RD: phase <= '0;
        ST_COMB_WR: begin
          case (phase)
            2'd0: begin
              // Delay output arrives; its d2 product is held for the lowpass sum.
              o_val    <= $signed(comb_rdata);
              prod_reg <= 48'(mul_p);
              phase    <= 2'd1;
            end
            2'd1: begin
              lp_val       <= sat24(lp_sum);
              lp_state[ci] <= sat24(lp_sum);
              phase        <= 2'd2;
            end
            default: begin
              // The line is written this cycle; the comb total saturates only
              // after the last comb of the channel.
              comb_total   <= comb_total_next;
              comb_pos[ci] <= comb_pos_next;
              phase        <= '0;
              if (last_c) acc <= sat24(48'(comb_total_next));
              else ci <= ci + CW'(1);
            end
          endcase
        end
        ST_AP_RD: ;
        ST_AP_WR: begin
          acc        <= sat24(ap_diff);
          ap_pos[ai] <= ap_pos_next;
          if (!last_a) ai <= ai + AW'(1);
        end
        ST_MIX: begin
          if (chan) out_r <= mix_sat;
          else out_l <= mix_sat;
          chan       <= 1'b1;
          ci         <= CW'(NUM_COMBS);
          ai         <= AW'(NUM_ALLPASSES);
          comb_total <= '0;
          phase      <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    smp_out.valid && !smp_out.ready |=>
      smp_out.valid && $stable(smp_out.left) && $stable(smp_out.right))
    else $error("output changed while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !smp_in.ready)
    else $error("ready while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg.ready |-> state == ST_IDLE)
    else $error("configuration taken while busy");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_CLEAR) |-> state == ST_IDLE)
    else $error("clear pass left to wrong state");
`endif

endmodule
